@@ sv/ppmd_pkg.sv @@
// Shared types, constants and elaboration-time functions for the power-law
// midtone dodge block. No dependencies.
`default_nettype none
package ppmd_pkg;

    localparam int CH_W             = 16;          // width of every channel field
    localparam int K_W              = 4;           // top-bit index of a 16-bit sample
    localparam int LOG_FRAC         = 24;          // fraction bits of log2
    localparam int LOG_W            = K_W + LOG_FRAC;
    localparam int EXP_W            = 16;          // Q2.14 exponent register
    localparam int EXP_FRAC         = 14;
    localparam int P_W              = LOG_W + EXP_W - EXP_FRAC;
    localparam int SH_W             = P_W - LOG_FRAC;
    localparam int MANT_W           = 32;
    localparam int ACC_W            = 33;
    localparam int DEF_CHANNEL_BITS = 16;
    localparam logic [EXP_W-1:0] EXP_RESET = 16'd16384;

    // input reg + log iterations + exponent product + root steps + shift + scale
    localparam int LAT = 1 + LOG_FRAC + 1 + LOG_FRAC + 1 + 1;

    typedef logic [LOG_FRAC-1:0][MANT_W-1:0] t_roots;

    typedef enum logic [1:0] {
        CASE_NORMAL,
        CASE_ZERO,
        CASE_FULL
    } t_case;

    function automatic logic [63:0] isqrt64(input logic [63:0] v);
        logic [63:0] op;
        logic [63:0] res;
        logic [63:0] one;
        op  = v;
        res = 64'd0;
        one = 64'd1 << 62;
        for (int j = 0; j < 32; j++) begin
            if (op >= res + one) begin
                op  = op - (res + one);
                res = (res >> 1) + one;
            end else begin
                res = res >> 1;
            end
            one = one >> 2;
        end
        return res;
    endfunction

    // r_i = 2^(-2^-(i+1)) in Q0.32
    function automatic t_roots make_roots();
        t_roots      r;
        logic [63:0] t;
        t    = isqrt64(64'd1 << 63);
        r[0] = t[MANT_W-1:0];
        for (int i = 1; i < LOG_FRAC; i++) begin
            t    = isqrt64({t[31:0], 32'd0});
            r[i] = t[MANT_W-1:0];
        end
        return r;
    endfunction

    function automatic logic [LOG_W-1:0] log2_q24(input logic [CH_W-1:0] v);
        logic [K_W-1:0]      k;
        logic [63:0]         m;
        logic [LOG_FRAC-1:0] fr;
        k = '0;
        for (int i = 0; i < CH_W; i++) begin
            if (v[i]) begin
                k = K_W'(i);
            end
        end
        m  = {48'd0, v} << (31 - k);
        fr = '0;
        for (int i = 0; i < LOG_FRAC; i++) begin
            m  = (m * m) >> 31;
            fr = {fr[LOG_FRAC-2:0], 1'b0};
            if (m[32]) begin
                m     = m >> 1;
                fr[0] = 1'b1;
            end
        end
        return {k, fr};
    endfunction

    localparam t_roots ROOTS = make_roots();

endpackage
`default_nettype wire

@@ sv/ppmd_in_if.sv @@
// Input pixel channel: valid/ready handshake with an RGBA request.
// Depends on ppmd_pkg.
`default_nettype none
interface ppmd_in_if;
    logic                      valid;
    logic                      ready;
    logic [ppmd_pkg::CH_W-1:0] red_in;
    logic [ppmd_pkg::CH_W-1:0] green_in;
    logic [ppmd_pkg::CH_W-1:0] blue_in;
    logic [ppmd_pkg::CH_W-1:0] alpha_in;
    logic                      last_pixel;

    modport source (output valid, red_in, green_in, blue_in, alpha_in, last_pixel,
                    input ready);
    modport sink   (input valid, red_in, green_in, blue_in, alpha_in, last_pixel,
                    output ready);
endinterface
`default_nettype wire

@@ sv/ppmd_out_if.sv @@
// Output pixel channel: valid/ready handshake with an adjusted RGBA request.
// Depends on ppmd_pkg.
`default_nettype none
interface ppmd_out_if;
    logic                      valid;
    logic                      ready;
    logic [ppmd_pkg::CH_W-1:0] red_out;
    logic [ppmd_pkg::CH_W-1:0] green_out;
    logic [ppmd_pkg::CH_W-1:0] blue_out;
    logic [ppmd_pkg::CH_W-1:0] alpha_out;
    logic                      last_out;

    modport source (output valid, red_out, green_out, blue_out, alpha_out, last_out,
                    input ready);
    modport sink   (input valid, red_out, green_out, blue_out, alpha_out, last_out,
                    output ready);
endinterface
`default_nettype wire

@@ sv/ppmd_lane.sv @@
// One color lane: pipelined log2, exponent scaling and root-product exp2.
// Depends on ppmd_pkg.
`default_nettype none
module ppmd_lane #(
    parameter int CHANNEL_BITS = ppmd_pkg::DEF_CHANNEL_BITS
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_en,
    input  wire logic [ppmd_pkg::CH_W-1:0]    i_x,
    input  wire logic [ppmd_pkg::EXP_W-1:0]   i_exp,
    output logic      [ppmd_pkg::CH_W-1:0]    o_y
);
    localparam int NF = ppmd_pkg::LOG_FRAC;
    localparam int L  = ppmd_pkg::LAT;
    localparam logic [ppmd_pkg::CH_W-1:0] FS =
        ppmd_pkg::CH_W'((32'd1 << CHANNEL_BITS) - 32'd1);
    localparam logic [ppmd_pkg::LOG_W-1:0] LOG_FS = ppmd_pkg::log2_q24(FS);

    logic [ppmd_pkg::MANT_W-1:0] r_m  [0:NF];
    logic [NF-1:0]               r_fr [0:NF];
    logic [ppmd_pkg::K_W-1:0]    r_k  [0:NF];
    logic [ppmd_pkg::P_W-1:0]    r_pp [0:NF];
    logic [ppmd_pkg::ACC_W-1:0]  r_acc[1:NF];
    logic [ppmd_pkg::ACC_W-1:0]  r_sh;
    ppmd_pkg::t_case             r_cs [0:L-2];
    logic [ppmd_pkg::CH_W-1:0]   r_y;

    // input stage: classify, find top bit, normalize mantissa
    logic [ppmd_pkg::K_W-1:0]    n_k;
    ppmd_pkg::t_case             n_cs;
    always_comb begin
        n_k = '0;
        for (int i = 0; i < ppmd_pkg::CH_W; i++) begin
            if (i_x[i]) begin
                n_k = ppmd_pkg::K_W'(i);
            end
        end
        if (i_exp == '0 || i_x >= FS) begin
            n_cs = ppmd_pkg::CASE_FULL;
        end else if (i_x == '0) begin
            n_cs = ppmd_pkg::CASE_ZERO;
        end else begin
            n_cs = ppmd_pkg::CASE_NORMAL;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_k[0]  <= n_k;
            r_m[0]  <= ppmd_pkg::MANT_W'({16'd0, i_x} << (5'd31 - {1'b0, n_k}));
            r_fr[0] <= '0;
            r_cs[0] <= n_cs;
        end
    end

    for (genvar s = 1; s < L - 1; s++) begin : g_cs
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_cs[s] <= r_cs[s-1];
            end
        end
    end

    // log2 fraction: square and renormalize, one bit per stage
    for (genvar j = 1; j <= NF; j++) begin : g_log
        logic [63:0] w_sq;
        logic [32:0] w_t;
        assign w_sq = 64'(r_m[j-1]) * 64'(r_m[j-1]);
        assign w_t  = w_sq[63:31];
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_k[j]  <= r_k[j-1];
                r_m[j]  <= w_t[32] ? w_t[32:1] : w_t[31:0];
                r_fr[j] <= {r_fr[j-1][NF-2:0], w_t[32]};
            end
        end
    end

    // p = round((log_fs - log_x) * exponent)
    logic [ppmd_pkg::LOG_W-1:0]           w_d;
    logic [ppmd_pkg::LOG_W+ppmd_pkg::EXP_W-1:0] w_pd;
    assign w_d  = LOG_FS - {r_k[NF], r_fr[NF]};
    assign w_pd = (ppmd_pkg::LOG_W+ppmd_pkg::EXP_W)'(w_d) * i_exp
                  + ((ppmd_pkg::LOG_W+ppmd_pkg::EXP_W)'(1) << (ppmd_pkg::EXP_FRAC - 1));
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pp[0] <= w_pd[ppmd_pkg::LOG_W+ppmd_pkg::EXP_W-1:ppmd_pkg::EXP_FRAC];
        end
    end

    // 2^-frac as a product of roots, one factor per stage
    for (genvar i = 1; i <= NF; i++) begin : g_exp
        logic [ppmd_pkg::ACC_W-1:0] w_a;
        logic [64:0]                w_pr;
        if (i == 1) begin : g_first
            assign w_a = ppmd_pkg::ACC_W'(1) << 32;
        end else begin : g_rest
            assign w_a = r_acc[i-1];
        end
        assign w_pr = 65'(w_a) * 65'(ppmd_pkg::ROOTS[i-1]);
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_pp[i]  <= r_pp[i-1];
                r_acc[i] <= r_pp[i-1][NF-i] ? w_pr[64:32] : w_a;
            end
        end
    end

    // integer part of p: plain right shift
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sh <= r_acc[NF] >> r_pp[NF][ppmd_pkg::P_W-1:NF];
        end
    end

    // scale to full scale, round, saturate, apply special cases
    logic [49:0] w_sc;
    logic [17:0] w_res;
    always_comb begin
        w_sc  = 50'(FS) * 50'(r_sh) + (50'd1 << 31);
        w_res = w_sc[49:32];
    end
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            case (r_cs[L-2])
                ppmd_pkg::CASE_FULL: r_y <= FS;
                ppmd_pkg::CASE_ZERO: r_y <= '0;
                default:             r_y <= (w_res > 18'(FS)) ? FS : w_res[15:0];
            endcase
        end
    end

    assign o_y = r_y;
endmodule
`default_nettype wire

@@ sv/pixel_power_law_midtone_dodge_top.sv @@
// Power-law midtone dodge: three parallel color lanes plus alpha/last delay line.
// Depends on ppmd_pkg, ppmd_in_if, ppmd_out_if and ppmd_lane.
//
// Each input pixel gives one output pixel: red, green and blue become
// FS * (x/FS)^e, rounded to nearest and saturated at FS = 2^CHANNEL_BITS-1,
// where e is the Q2.14 exponent register (reset 1.0). Alpha and the last flag
// pass through. An exponent of zero forces full scale on every color; a zero
// sample otherwise gives zero; a sample at or above FS gives FS. The block
// takes one pixel per clock unless the output is stalled. Each lane holds the
// fixed-point log2 (24 squaring stages) and the exp2 root product (24
// multiply stages). The whole pipeline holds while the output
// request is stalled, so input ready follows output ready combinationally
// whenever the final stage holds a result. Write the exponent only while no
// pixel is in flight.
`default_nettype none
module pixel_power_law_midtone_dodge_top #(
    parameter int CHANNEL_BITS = ppmd_pkg::DEF_CHANNEL_BITS
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_we,
    input  wire logic [ppmd_pkg::EXP_W-1:0]  i_cfg_wdata,
    ppmd_in_if.sink                          i_pix,
    ppmd_out_if.source                       o_pix
);
    localparam int L = ppmd_pkg::LAT;
    localparam logic [ppmd_pkg::CH_W-1:0] FS =
        ppmd_pkg::CH_W'((32'd1 << CHANNEL_BITS) - 32'd1);

    logic [ppmd_pkg::EXP_W-1:0] r_exp;
    logic                       r_vld [0:L-1];
    logic [ppmd_pkg::CH_W-1:0]  r_alp [0:L-1];
    logic                       r_lst [0:L-1];
    logic                       w_en;
    logic [ppmd_pkg::CH_W-1:0]  w_red;
    logic [ppmd_pkg::CH_W-1:0]  w_grn;
    logic [ppmd_pkg::CH_W-1:0]  w_blu;

    // advance everything unless a finished result is waiting on the sink
    assign w_en        = !r_vld[L-1] || o_pix.ready;
    assign i_pix.ready = w_en;

    // exponent register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp <= ppmd_pkg::EXP_RESET;
        end else if (i_cfg_we) begin
            r_exp <= i_cfg_wdata;
        end
    end

    // valid tokens: cleared on reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < L; s++) begin
                r_vld[s] <= 1'b0;
            end
        end else if (w_en) begin
            r_vld[0] <= i_pix.valid;
            for (int s = 1; s < L; s++) begin
                r_vld[s] <= r_vld[s-1];
            end
        end
    end

    // alpha and last ride alongside the lanes
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_alp[0] <= i_pix.alpha_in;
            r_lst[0] <= i_pix.last_pixel;
            for (int s = 1; s < L; s++) begin
                r_alp[s] <= r_alp[s-1];
                r_lst[s] <= r_lst[s-1];
            end
        end
    end

    // one lane per color channel
    ppmd_lane #(.CHANNEL_BITS(CHANNEL_BITS)) u_lane_r (
        .i_clk (i_clk), .i_en (w_en), .i_x (i_pix.red_in),   .i_exp (r_exp), .o_y (w_red)
    );
    ppmd_lane #(.CHANNEL_BITS(CHANNEL_BITS)) u_lane_g (
        .i_clk (i_clk), .i_en (w_en), .i_x (i_pix.green_in), .i_exp (r_exp), .o_y (w_grn)
    );
    ppmd_lane #(.CHANNEL_BITS(CHANNEL_BITS)) u_lane_b (
        .i_clk (i_clk), .i_en (w_en), .i_x (i_pix.blue_in),  .i_exp (r_exp), .o_y (w_blu)
    );

    // merge lanes and side channel into the result request
    assign o_pix.valid     = r_vld[L-1];
    assign o_pix.red_out   = w_red;
    assign o_pix.green_out = w_grn;
    assign o_pix.blue_out  = w_blu;
    assign o_pix.alpha_out = r_alp[L-1];
    assign o_pix.last_out  = r_lst[L-1];

`ifndef SYNTHESIS
    a_rst_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_pix.valid)
        else $error("result valid right after reset");
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pix.valid && !o_pix.ready) |-> !i_pix.ready)
        else $error("input taken while result stalled");
    a_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pix.valid |-> (o_pix.red_out <= FS && o_pix.green_out <= FS
                         && o_pix.blue_out <= FS))
        else $error("color above full scale");
`endif
endmodule
`default_nettype wire

@@ verif/testbench.sv @@
// Testbench for pixel_power_law_midtone_dodge_top: directed and random pixel
// traffic checked against an in-bench fixed-point power-law predictor.
// Depends on ppmd_pkg, ppmd_in_if, ppmd_out_if and the RTL top.
`timescale 1ns / 1ps
module testbench;

    localparam int PIPE_DEPTH  = 52;    // matches ppmd_pkg::LAT, the lane pipeline depth
    localparam int STALL_LIMIT = 4000;  // cycles without any request moving
    localparam logic [ppmd_pkg::CH_W-1:0] FULL = 16'hFFFF;

    typedef struct {
        logic [ppmd_pkg::CH_W-1:0] red;
        logic [ppmd_pkg::CH_W-1:0] green;
        logic [ppmd_pkg::CH_W-1:0] blue;
        logic [ppmd_pkg::CH_W-1:0] alpha;
        logic                      last;
    } t_pixel;

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       i_cfg_we;
    logic [ppmd_pkg::EXP_W-1:0] i_cfg_wdata;

    ppmd_in_if  pix_in();
    ppmd_out_if pix_out();

    pixel_power_law_midtone_dodge_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_pix       (pix_in),
        .o_pix       (pix_out)
    );

    // Clock: 8 ns period.
    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    // Predictor state: the exponent the block should hold, and the fractional
    // power-of-two roots 2^(-2^-i) in Q0.32.
    logic [ppmd_pkg::EXP_W-1:0] exponent_q14;
    logic [63:0]                half_roots [1:ppmd_pkg::LOG_FRAC];
    logic [63:0]                log_full;

    t_pixel adjusted_pixels [$];   // expected results, oldest first
    int     error_count;
    int     sender_idle_pct;
    int     receiver_stall_pct;
    int     quiet_cycles;

    // Floor square root, one result bit per pass.
    function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
        logic [63:0] rem;
        logic [63:0] root;
        logic [63:0] bitv;
        rem  = v;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > rem) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (rem >= root + bitv) begin
                rem  = rem - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    // log2 as Q8.24: top-bit index plus 24 fraction bits by repeated squaring.
    function automatic logic [63:0] log2_fixed(input logic [31:0] v);
        int          top;
        logic [63:0] mant;
        logic [63:0] frac;
        top = 0;
        while (top < 31 && (v >> (top + 1)) != 0) top++;
        mant = {32'd0, v} << (31 - top);
        frac = 0;
        for (int i = 0; i < ppmd_pkg::LOG_FRAC; i++) begin
            mant = (mant * mant) >> 31;
            frac = frac << 1;
            if (mant >= (64'd1 << 32)) begin
                mant = mant >> 1;
                frac = frac | 64'd1;
            end
        end
        return (64'(top) << ppmd_pkg::LOG_FRAC) | frac;
    endfunction

    // FS * (x/FS)^e with rounding and saturation.
    function automatic logic [ppmd_pkg::CH_W-1:0] dodge_sample(
            input logic [ppmd_pkg::CH_W-1:0] x);
        logic [63:0] log_gap;
        logic [63:0] scaled;
        logic [63:0] acc;
        logic [63:0] res;
        if (exponent_q14 == 0) return FULL;
        if (x == 0) return '0;
        if (x >= FULL) return FULL;
        log_gap = log_full - log2_fixed({16'd0, x});
        scaled  = (log_gap * 64'(exponent_q14) + (64'd1 << 13)) >> ppmd_pkg::EXP_FRAC;
        acc     = 64'd1 << 32;
        for (int i = 1; i <= ppmd_pkg::LOG_FRAC; i++) begin
            if (scaled[ppmd_pkg::LOG_FRAC - i]) acc = (acc * half_roots[i]) >> 32;
        end
        acc = acc >> (scaled >> ppmd_pkg::LOG_FRAC);
        res = (64'(FULL) * acc + (64'd1 << 31)) >> 32;
        if (res > 64'(FULL)) res = 64'(FULL);
        return res[ppmd_pkg::CH_W-1:0];
    endfunction

    task automatic report_mismatch(input string what,
                                   input logic [ppmd_pkg::CH_W-1:0] got,
                                   input logic [ppmd_pkg::CH_W-1:0] want);
        $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    // Receiver: stall at random, check each accepted result against the
    // oldest expectation, and count cycles in which no request moves.
    always @(posedge i_clk) begin
        t_pixel want;
        if (!i_rst_n) begin
            quiet_cycles <= 0;
        end else begin
            if ((pix_out.valid && pix_out.ready) || (pix_in.valid && pix_in.ready)
                    || adjusted_pixels.size() == 0 && !pix_in.valid)
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (pix_out.valid && pix_out.ready) begin
                if (adjusted_pixels.size() == 0) begin
                    report_mismatch("unexpected result", pix_out.red_out, '0);
                end else begin
                    want = adjusted_pixels.pop_front();
                    if (pix_out.red_out !== want.red)
                        report_mismatch("red", pix_out.red_out, want.red);
                    if (pix_out.green_out !== want.green)
                        report_mismatch("green", pix_out.green_out, want.green);
                    if (pix_out.blue_out !== want.blue)
                        report_mismatch("blue", pix_out.blue_out, want.blue);
                    if (pix_out.alpha_out !== want.alpha)
                        report_mismatch("alpha", pix_out.alpha_out, want.alpha);
                    if (pix_out.last_out !== want.last)
                        report_mismatch("last", 16'(pix_out.last_out), 16'(want.last));
                end
            end
        end
        pix_out.ready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    // Watchdog: end the run if traffic stops moving.
    always @(posedge i_clk) begin
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Send one pixel; hold it until accepted, then maybe idle the source.
    // Call at a rising edge; returns at a rising edge.
    task automatic send_pixel(input t_pixel px);
        t_pixel want;
        pix_in.valid      <= 1'b1;
        pix_in.red_in     <= px.red;
        pix_in.green_in   <= px.green;
        pix_in.blue_in    <= px.blue;
        pix_in.alpha_in   <= px.alpha;
        pix_in.last_pixel <= px.last;
        do @(posedge i_clk); while (!pix_in.ready);
        want.red   = dodge_sample(px.red);
        want.green = dodge_sample(px.green);
        want.blue  = dodge_sample(px.blue);
        want.alpha = px.alpha;
        want.last  = px.last;
        adjusted_pixels.push_back(want);
        if ($urandom_range(99) < sender_idle_pct) begin
            pix_in.valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < sender_idle_pct);
        end
    endtask

    // Drop valid and hold until every expected result is back and the
    // pipeline has had time to empty.
    task automatic drain_pipeline();
        pix_in.valid <= 1'b0;
        @(posedge i_clk);
        while (adjusted_pixels.size() != 0) @(posedge i_clk);
        repeat (PIPE_DEPTH + 4) @(posedge i_clk);
    endtask

    // Write the exponent register while the block is idle.
    task automatic write_exponent(input logic [ppmd_pkg::EXP_W-1:0] value);
        drain_pipeline();
        i_cfg_we     <= 1'b1;
        i_cfg_wdata  <= value;
        @(posedge i_clk);
        i_cfg_we     <= 1'b0;
        exponent_q14 = value;
    endtask

    function automatic logic [ppmd_pkg::CH_W-1:0] pick_sample();
        case ($urandom_range(9))
            0: return '0;
            1: return FULL;
            2: return FULL - 16'd1;
            3: return 16'd1;
            4: return 16'($urandom_range(255));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic t_pixel random_pixel();
        t_pixel px;
        px.red   = pick_sample();
        px.green = pick_sample();
        px.blue  = pick_sample();
        px.alpha = 16'($urandom);
        px.last  = ($urandom_range(15) == 0);
        return px;
    endfunction

    // Extremes of every field, zero and full-scale samples, alpha/last pass.
    task automatic test_directed();
        t_pixel px;
        logic [ppmd_pkg::CH_W-1:0] probes [8] = '{16'h0000, 16'h0001, 16'h0002, 16'h00FF,
                                                   16'h8000, 16'hFFFE, 16'hFFFF, 16'h5555};
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        // Reset exponent (1.0): output should track input.
        for (int i = 0; i < 8; i++) begin
            px = '{probes[i], probes[7 - i], probes[(i + 3) % 8], probes[i], i[0]};
            send_pixel(px);
        end
        // Zero exponent: every color to full scale, zero samples included.
        write_exponent('0);
        send_pixel('{16'h0000, 16'h0001, 16'hFFFF, 16'h0000, 1'b0});
        send_pixel('{16'h1234, 16'h0000, 16'hAAAA, 16'hFFFF, 1'b1});
        // Largest exponent: deep darkening, zero and full scale kept.
        write_exponent(16'hFFFF);
        for (int i = 0; i < 8; i++) begin
            px = '{probes[i], probes[(i + 1) % 8], probes[(i + 5) % 8], ~probes[i], ~i[0]};
            send_pixel(px);
        end
        // Smallest nonzero exponent.
        write_exponent(16'd1);
        send_pixel('{16'h0001, 16'h0000, 16'h7FFF, 16'hAAAA, 1'b0});
        send_pixel('{16'hFFFE, 16'hFFFF, 16'h0100, 16'h5555, 1'b1});
    endtask

    // Random pixels over several exponents, one idling pattern per phase.
    task automatic test_random_phase(input int idle_pct, input int stall_pct,
                                     input int count);
        logic [ppmd_pkg::EXP_W-1:0] exps [6] = '{ppmd_pkg::EXP_RESET, 16'd8192,
                                                 16'd10923, 16'hFFFF, 16'd0, 16'd16000};
        for (int s = 0; s < 4; s++) begin
            write_exponent(s == 3 ? 16'($urandom) : exps[$urandom_range(5)]);
            sender_idle_pct    = idle_pct;
            receiver_stall_pct = stall_pct;
            for (int i = 0; i < count / 4; i++) send_pixel(random_pixel());
            sender_idle_pct = 0;
        end
    endtask

    // Burst, then pause the source until every result is back, then burst again.
    task automatic test_pause_until_empty();
        receiver_stall_pct = 50;
        for (int i = 0; i < 30; i++) send_pixel(random_pixel());
        drain_pipeline();
        for (int i = 0; i < 30; i++) send_pixel(random_pixel());
    endtask

    initial begin
        error_count        = 0;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        exponent_q14       = ppmd_pkg::EXP_RESET;
        half_roots[1] = floor_sqrt(64'd1 << 63);
        for (int i = 2; i <= ppmd_pkg::LOG_FRAC; i++)
            half_roots[i] = floor_sqrt(half_roots[i - 1] << 32);
        log_full = log2_fixed({16'd0, FULL});

        i_rst_n           <= 1'b0;
        i_cfg_we          <= 1'b0;
        i_cfg_wdata       <= '0;
        pix_in.valid      <= 1'b0;
        pix_in.red_in     <= '0;
        pix_in.green_in   <= '0;
        pix_in.blue_in    <= '0;
        pix_in.alpha_in   <= '0;
        pix_in.last_pixel <= 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random_phase(0, 0, 400);
        test_random_phase(75, 0, 360);
        test_random_phase(0, 75, 360);
        test_random_phase(32, 32, 360);
        test_pause_until_empty();
        write_exponent(ppmd_pkg::EXP_RESET);
        receiver_stall_pct = 0;

        drain_pipeline();
        if (error_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule
